// ===== sv/mfc_pkg.sv =====
package mfc_pkg;

    // Command codes carried in the input tuser.
    localparam logic CMD_PACK   = 1'b0;
    localparam logic CMD_UNPACK = 1'b1;

    // Configuration register indexes.
    localparam logic REG_EXP_WIDTH  = 1'b0;
    localparam logic REG_MANT_WIDTH = 1'b1;

    // Register widths and reset values.
    localparam int EXP_W  = 4;
    localparam int MANT_W = 5;
    localparam logic [EXP_W-1:0]  EXP_RESET  = 4'd5;
    localparam logic [MANT_W-1:0] MANT_RESET = 5'd10;

    // Single-precision layout.
    localparam logic [7:0] SP_BIAS = 8'd127;
    localparam logic [4:0] SP_MANT_BITS = 5'd23;

    // Stage 1 payload: operand plus the format's extreme codes.
    typedef struct packed {
        logic              cmd;
        logic [31:0]       operand;
        logic [EXP_W-1:0]  exp_w;
        logic [MANT_W-1:0] mant_w;
        logic [30:0]       max_code;
        logic [30:0]       min_code;
    } s1_t;

    // Stage 2 payload: candidate results and compare bounds.
    typedef struct packed {
        logic        cmd;
        logic [30:0] mag;
        logic [31:0] sp_a;
        logic [30:0] min_sp;
        logic [31:0] max_res;
        logic [31:0] min_res;
        logic [31:0] norm_res;
    } s2_t;

    // Final result.
    typedef struct packed {
        logic [31:0] result;
        logic        saturated;
    } res_t;

    // Limit the exponent width to 2..8.
    function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] e);
        logic [EXP_W-1:0] r;
        r = e;
        if (e < 4'd2) r = 4'd2;
        if (e > 4'd8) r = 4'd8;
        return r;
    endfunction

    // Limit the mantissa width to 2..23.
    function automatic logic [MANT_W-1:0] clamp_mant(input logic [MANT_W-1:0] m);
        logic [MANT_W-1:0] r;
        r = m;
        if (m < 5'd2) r = 5'd2;
        if (m > 5'd23) r = 5'd23;
        return r;
    endfunction

    // Rebuild single-precision bits from a packed small float.
    function automatic logic [31:0] unpack_sp(input logic [31:0] v,
                                              input logic [EXP_W-1:0] e,
                                              input logic [MANT_W-1:0] m);
        logic [2:0]  em;
        logic [4:0]  spos;
        logic [4:0]  epos;
        logic        sgn;
        logic [31:0] shv;
        logic [6:0]  mag;
        logic        eneg;
        logic [7:0]  biased;
        logic [31:0] mmask;
        logic [31:0] mant_sh;
        em      = 3'(e - 4'd1);
        spos    = 5'({1'b0, e} + m);
        epos    = 5'({2'b0, em} + m);
        sgn     = v[spos];
        shv     = v >> m;
        mag     = shv[6:0] & 7'((8'd1 << em) - 8'd1);
        eneg    = v[epos];
        biased  = eneg ? (SP_BIAS - {1'b0, mag}) : (SP_BIAS + {1'b0, mag});
        mmask   = (32'd1 << m) - 32'd1;
        mant_sh = (v & mmask) << (SP_MANT_BITS - m);
        return {sgn, biased, mant_sh[22:0]};
    endfunction

endpackage

// ===== sv/mfc_front.sv =====
module mfc_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         cmd,
    input  logic [31:0]  operand,
    input  logic [3:0]   exp_width,
    input  logic [4:0]   mant_width,
    output logic         out_valid,
    input  logic         out_ready,
    output mfc_pkg::s1_t out_data
);
    import mfc_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    s1_t              data_reg;
    s1_t              data_next;
    logic [EXP_W-1:0]  e;
    logic [MANT_W-1:0] m;
    logic [2:0]        em;
    logic [31:0]       maxmag;
    logic [31:0]       mmask;
    logic [31:0]       max_code;
    logic [31:0]       min_code;

    // Clamp the widths and build the largest and smallest codes.
    always_comb
    begin
        e        = clamp_exp(exp_width);
        m        = clamp_mant(mant_width);
        em       = 3'(e - 4'd1);
        maxmag   = (32'd1 << em) - 32'd1;
        mmask    = (32'd1 << m) - 32'd1;
        max_code = (maxmag << m) | mmask;
        min_code = (((32'd1 << e) - 32'd2) << m) | 32'd1;
        data_next.cmd      = cmd;
        data_next.operand  = operand;
        data_next.exp_w    = e;
        data_next.mant_w   = m;
        data_next.max_code = max_code[30:0];
        data_next.min_code = min_code[30:0];
    end

    // Stage holds while the next stage is full and stalled.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/mfc_expand.sv =====
module mfc_expand (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  mfc_pkg::s1_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output mfc_pkg::s2_t out_data
);
    import mfc_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    s2_t         data_reg;
    s2_t         data_next;
    logic [2:0]  em;
    logic [4:0]  spos;
    logic [31:0] sbit;
    logic [31:0] a_src;
    logic [7:0]  biased;
    logic        neg;
    logic [7:0]  amag;
    logic [7:0]  maxmag;
    logic [7:0]  exp_f;
    logic [31:0] mant_f;

    // Unpack the operand or the largest code, unpack the smallest code,
    // and form the in-range packed value.
    always_comb
    begin
        em     = 3'(in_data.exp_w - 4'd1);
        spos   = 5'({1'b0, in_data.exp_w} + in_data.mant_w);
        sbit   = {31'd0, in_data.operand[31]} << spos;
        a_src  = (in_data.cmd == CMD_UNPACK) ? in_data.operand : {1'b0, in_data.max_code};
        biased = in_data.operand[30:23];
        neg    = biased < SP_BIAS;
        amag   = neg ? (SP_BIAS - biased) : (biased - SP_BIAS);
        maxmag = (8'd1 << em) - 8'd1;
        exp_f  = ({7'd0, neg} << em) | (amag & maxmag);
        mant_f = {9'd0, in_data.operand[22:0]} >> (SP_MANT_BITS - in_data.mant_w);

        data_next.cmd      = in_data.cmd;
        data_next.mag      = in_data.operand[30:0];
        data_next.sp_a     = unpack_sp(a_src, in_data.exp_w, in_data.mant_w);
        data_next.min_sp   = 31'(unpack_sp({1'b0, in_data.min_code}, in_data.exp_w,
                                           in_data.mant_w));
        data_next.max_res  = sbit | {1'b0, in_data.max_code};
        data_next.min_res  = sbit | {1'b0, in_data.min_code};
        data_next.norm_res = sbit | ({24'd0, exp_f} << in_data.mant_w) | mant_f;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/mfc_clamp.sv =====
module mfc_clamp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mfc_pkg::s2_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output mfc_pkg::res_t out_data
);
    import mfc_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;
    res_t data_next;

    // Pick the result: unpacked bits, a clamped code, or the packed value.
    always_comb
    begin
        data_next.saturated = 1'b0;
        data_next.result    = in_data.norm_res;
        priority if (in_data.cmd == CMD_UNPACK)
        begin
            data_next.result = in_data.sp_a;
        end
        else if (in_data.mag >= in_data.sp_a[30:0])
        begin
            data_next.saturated = 1'b1;
            data_next.result    = in_data.max_res;
        end
        else if (in_data.mag <= in_data.min_sp)
        begin
            data_next.saturated = 1'b1;
            data_next.result    = in_data.min_res;
        end
        else
        begin
            data_next.result = in_data.norm_res;
        end
    end

    // This stage is the output register.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/float_to_minifloat_codec_top.sv =====
// Single-precision to small-float codec, pack and unpack.
// Each accepted input transaction passes through three register stages in a row to its output transaction.
// Throughput: one transaction per cycle while the output is not stalled.
// Each stage holds only while the stage after it is full and stalled.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the widths
// to 5 exponent bits and 10 mantissa bits.
module float_to_minifloat_codec_top (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic        s_tuser,   // [0] cmd
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result
    output logic        m_tuser    // [0] saturated
);
    import mfc_pkg::*;

    logic [EXP_W-1:0]  exp_width_reg;
    logic [MANT_W-1:0] mant_width_reg;
    logic              s1_valid;
    logic              s1_ready;
    s1_t               s1_data;
    logic              s2_valid;
    logic              s2_ready;
    s2_t               s2_data;
    res_t              res_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_width_reg  <= EXP_RESET;
            mant_width_reg <= MANT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXP_WIDTH:  exp_width_reg  <= cfg_data[EXP_W-1:0];
                REG_MANT_WIDTH: mant_width_reg <= cfg_data;
                default:        exp_width_reg  <= exp_width_reg;
            endcase
        end
    end

    // Stage 1: clamp widths, build extreme codes.
    mfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tuser),
        .operand    (s_tdata),
        .exp_width  (exp_width_reg),
        .mant_width (mant_width_reg),
        .out_valid  (s1_valid),
        .out_ready  (s1_ready),
        .out_data   (s1_data)
    );

    // Stage 2: unpack and form candidates.
    mfc_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage 3: compare, select, output register.
    mfc_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata = res_data.result;
    assign m_tuser = res_data.saturated;

`ifndef SYNTHESIS
    // Input backpressure only when every stage is full and the output stalls.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && s1_valid && s2_valid))
        else $error("input stalled while the pipeline has room");

    // Both clamp codes end in a mantissa bit of one.
    a_sat_code_lsb: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[0] == 1'b1))
        else $error("saturated result is not a clamp code");

    // A mantissa width write lands in the register.
    a_cfg_mant: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == REG_MANT_WIDTH)) |=> (mant_width_reg == $past(cfg_data)))
        else $error("mantissa width write lost");
`endif

endmodule
